// ----- rtl/lslf_pkg.sv -----
// Types, register codes and helpers shared by the literal substitute line filter.
package lslf_pkg;

  localparam int PAT_CELLS = 8;
  localparam int RUN_MAX   = 8;
  localparam int REP_LIMIT = 8;
  localparam int CNT_W     = 3;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [1:0] MODE_PRINT  = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam int FLAG_GLOBAL = 0;
  localparam int FLAG_QUIET  = 1;

  typedef enum logic [2:0] {
    CFG_MODE,
    CFG_FLAGS,
    CFG_RANGE_START,
    CFG_RANGE_END,
    CFG_PATTERN_BYTES,
    CFG_PATTERN_LENGTH,
    CFG_REPLACEMENT_BYTES,
    CFG_REPLACEMENT_LENGTH
  } cfg_index_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [3:0]              len;
  } run_t;

  function automatic logic [3:0] pat_len_clamp(input logic [3:0] n);
    logic [3:0] r;
    r = n;
    if (n == 4'd0) r = 4'd1;
    else if (n > 4'(PAT_CELLS)) r = 4'(PAT_CELLS);
    return r;
  endfunction

  function automatic logic [3:0] rep_len_clamp(input logic [3:0] n);
    logic [3:0] r;
    r = n;
    if (n > 4'(REP_LIMIT)) r = 4'(REP_LIMIT);
    return r;
  endfunction

endpackage

// ----- rtl/lslf_cell.sv -----
// One window cell: holds a held byte and the partial-match bit for its prefix length.
module lslf_cell
  import lslf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] pat_byte,
  input  logic [7:0] new_byte,
  input  logic [7:0] left_byte,
  input  logic       left_match,
  output logic [7:0] byte_q,
  output logic       match_q,
  output logic       match_nxt
);

  logic [7:0] byte_r;
  logic       match_r;

  assign match_nxt = left_match && (pat_byte == new_byte);
  assign byte_q    = byte_r;
  assign match_q   = match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.clear) begin
      match_r <= 1'b0;
    end else if (ctrl.shift) begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= left_byte;
    end
  end

endmodule

// ----- rtl/lslf_run_fifo.sv -----
// Two-slot queue of output runs, serialized one byte per beat.
module lslf_run_fifo
  import lslf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  run_t      push_run,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  run_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [2:0] pos_r;

  run_t       head;
  logic       last;
  logic       take;
  logic       pop;

  assign head      = slot_r[rd_ptr_r];
  assign last      = ({1'b0, pos_r} == (head.len - 4'd1));
  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign take      = out_valid && !out_stall;
  assign pop       = take && last;

  assign out_item.out_byte    = head.bytes[pos_r];
  assign out_item.last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      pos_r    <= 3'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
      if (pop) pos_r <= 3'd0;
      else if (take) pos_r <= pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ----- rtl/literal_substitute_line_filter.sv -----
// Top level of the streaming literal find-and-replace line filter.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_item_t  (kind, data_byte)
//   out_     output     out_valid/out_stall  out_item_t (out_byte, last_of_run)
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input beat per cycle while in_stall is low; an item yielding n bytes is
// sent in n beats. Results queue in a two-run buffer; in_stall rises only while
// both slots are taken. The held window is a row of PAT_CELLS cells shifted
// one place per substituted byte. Reset is synchronous: registers return to
// their reset values and the window empties. cfg_ready is always high.
module literal_substitute_line_filter
  import lslf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [1:0]  mode_r;
  logic [1:0]  flags_r;
  logic [31:0] range_start_r;
  logic [31:0] range_end_r;
  logic [63:0] pat_r;
  logic [3:0]  pat_len_r;
  logic [63:0] rep_r;
  logic [3:0]  rep_len_r;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [31:0]      line_r;
  logic [31:0]      line_nxt;
  logic             replaced_r;
  logic             replaced_nxt;

  logic [7:0] cell_byte  [PAT_CELLS];
  logic       cell_match [PAT_CELLS];
  logic       cell_mnx   [PAT_CELLS];
  cell_ctrl_t cell_ctrl;

  logic        accept;
  logic        cfg_wr;
  logic        cfg_clear;
  logic        fifo_full;
  logic [7:0]  b;
  logic        is_nl;
  logic        is_eos;
  logic        quiet;
  logic        in_range;
  logic        sub_mode;
  logic        run_sub;
  logic        lock;
  logic [3:0]  plen;
  logic [3:0]  rlen;
  logic [2:0]  plen_m1;
  logic [3:0]  nn;
  logic        full_hit;
  logic [3:0]  keep_len;
  logic [7:0]  win_new [PAT_CELLS];
  logic [7:0]  win_src [PAT_CELLS];
  logic [2:0]  top_idx;
  logic [2:0]  src_idx;
  logic        push;
  run_t        push_run;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_wr && (cfg_index_t'(cfg_index) == CFG_MODE ||
                                cfg_index_t'(cfg_index) == CFG_FLAGS ||
                                cfg_index_t'(cfg_index) == CFG_PATTERN_BYTES ||
                                cfg_index_t'(cfg_index) == CFG_PATTERN_LENGTH);

  assign in_stall = fifo_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.data_byte;
  assign is_eos   = in_item.kind;
  assign is_nl    = (b == NEWLINE_BYTE);
  assign quiet    = flags_r[FLAG_QUIET];
  assign in_range = (line_r >= range_start_r) && (line_r <= range_end_r);
  assign sub_mode = (mode_r != MODE_PRINT) && (mode_r != MODE_DELETE);
  assign lock     = replaced_r && !flags_r[FLAG_GLOBAL];
  assign run_sub  = accept && !is_eos && sub_mode && !quiet && !lock;

  assign plen     = pat_len_clamp(pat_len_r);
  assign rlen     = rep_len_clamp(rep_len_r);
  assign plen_m1  = 3'(plen - 4'd1);
  assign nn       = {1'b0, cnt_r} + 4'd1;
  assign full_hit = (nn == plen) && cell_mnx[plen_m1];

  assign cell_ctrl.shift = run_sub;
  assign cell_ctrl.clear = cfg_clear || (accept && is_eos) ||
                           (run_sub && (full_hit || is_nl));

  genvar k;
  generate
    for (k = 0; k < PAT_CELLS; k++) begin : g_cell
      if (k == 0) begin : g_head
        lslf_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (cell_ctrl),
          .pat_byte   (pat_r[8*k +: 8]),
          .new_byte   (b),
          .left_byte  (b),
          .left_match (1'b1),
          .byte_q     (cell_byte[k]),
          .match_q    (cell_match[k]),
          .match_nxt  (cell_mnx[k])
        );
        assign win_new[k] = b;
      end else begin : g_body
        lslf_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (cell_ctrl),
          .pat_byte   (pat_r[8*k +: 8]),
          .new_byte   (b),
          .left_byte  (cell_byte[k-1]),
          .left_match (cell_match[k-1]),
          .byte_q     (cell_byte[k]),
          .match_q    (cell_match[k]),
          .match_nxt  (cell_mnx[k])
        );
        assign win_new[k] = cell_byte[k-1];
      end
    end
  endgenerate

  // longest suffix still matching a pattern prefix
  always_comb begin
    keep_len = 4'd0;
    for (int i = 0; i < PAT_CELLS; i++) begin
      if (cell_mnx[i]) keep_len = 4'(i + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < PAT_CELLS; i++) begin
      win_src[i] = is_eos ? cell_byte[i] : win_new[i];
    end
    top_idx = is_eos ? (cnt_r - 3'd1) : cnt_r;
  end

  always_comb begin
    push_run = '0;
    push     = 1'b0;
    src_idx  = 3'd0;
    if (is_eos) begin
      for (int j = 0; j < RUN_MAX; j++) begin
        src_idx = top_idx - 3'(j);
        push_run.bytes[j] = win_src[src_idx];
      end
      push_run.len = {1'b0, cnt_r};
      push         = accept && (cnt_r != 3'd0);
    end else if (mode_r == MODE_PRINT) begin
      push_run.bytes[0] = b;
      push_run.len      = 4'd1;
      push              = accept && (!quiet || in_range);
    end else if (mode_r == MODE_DELETE) begin
      push_run.bytes[0] = b;
      push_run.len      = 4'd1;
      push              = accept && !quiet && !in_range;
    end else if (lock) begin
      push_run.bytes[0] = b;
      push_run.len      = 4'd1;
      push              = accept && !quiet;
    end else if (full_hit) begin
      for (int j = 0; j < RUN_MAX; j++) begin
        push_run.bytes[j] = rep_r[8*j +: 8];
      end
      push_run.len = rlen;
      push         = run_sub && (rlen != 4'd0);
    end else begin
      for (int j = 0; j < RUN_MAX; j++) begin
        src_idx = top_idx - 3'(j);
        push_run.bytes[j] = win_src[src_idx];
      end
      push_run.len = is_nl ? nn : (nn - keep_len);
      push         = run_sub && (push_run.len != 4'd0);
    end
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    line_nxt     = line_r;
    replaced_nxt = replaced_r;
    if (accept) begin
      if (is_eos) begin
        cnt_nxt      = '0;
        line_nxt     = 32'd1;
        replaced_nxt = 1'b0;
      end else begin
        if (run_sub) begin
          if (full_hit || is_nl) cnt_nxt = '0;
          else cnt_nxt = keep_len[CNT_W-1:0];
          if (full_hit) replaced_nxt = 1'b1;
        end
        if (is_nl) begin
          replaced_nxt = 1'b0;
          if (line_r != 32'hFFFF_FFFF) line_nxt = line_r + 32'd1;
        end
      end
    end
    if (cfg_clear) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      line_r     <= 32'd1;
      replaced_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      line_r     <= line_nxt;
      replaced_r <= replaced_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 2'd0;
      flags_r       <= 2'd0;
      range_start_r <= 32'd1;
      range_end_r   <= 32'd1;
      pat_r         <= 64'd0;
      pat_len_r     <= 4'd1;
      rep_r         <= 64'd0;
      rep_len_r     <= 4'd0;
    end else if (cfg_wr) begin
      case (cfg_index_t'(cfg_index))
        CFG_MODE:               mode_r        <= cfg_data[1:0];
        CFG_FLAGS:              flags_r       <= cfg_data[1:0];
        CFG_RANGE_START:        range_start_r <= cfg_data[31:0];
        CFG_RANGE_END:          range_end_r   <= cfg_data[31:0];
        CFG_PATTERN_BYTES:      pat_r         <= cfg_data;
        CFG_PATTERN_LENGTH:     pat_len_r     <= cfg_data[3:0];
        CFG_REPLACEMENT_BYTES:  rep_r         <= cfg_data;
        CFG_REPLACEMENT_LENGTH: rep_len_r     <= cfg_data[3:0];
        default:                mode_r        <= mode_r;
      endcase
    end
  end

  lslf_run_fifo u_run_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_run  (push_run),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
